@@ sv/lrufr_pkg.sv @@
// ---------------------------------------------------------------------------
// lrufr_pkg: shared types and constants for the LRU frame replacer
// Frame geometry, the search beat that walks the cell row, and the
// update beat broadcast to all cells when an item commits.
// ---------------------------------------------------------------------------
package lrufr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 8;

  // slot index / recency rank width, at least one bit
  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  // width that holds the frame count itself
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  // active-frame register: the 4-bit write field, or wider if the count needs it
  localparam int ACT_W  = (CNT_W > 4) ? CNT_W : 4;

  localparam int FAULT_W = 16;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SLOT_W-1:0]    rank_t;
  typedef logic [SLOT_W:0]      limit_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ACT_W-1:0]     act_t;
  typedef logic [FAULT_W-1:0]   fault_t;

  localparam rank_t  RANK_MAX   = rank_t'(MAX_FRAMES - 1);
  localparam limit_t LIMIT_FULL = limit_t'(MAX_FRAMES);
  localparam act_t   ACT_RESET  = act_t'(MAX_FRAMES);
  localparam fault_t FAULT_MAX  = '1;

  // search beat: carries the reference and the running match / empty /
  // oldest picks from cell to cell
  typedef struct packed {
    logic  vld;
    page_t page;
    logic  found;
    slot_t hit_slot;
    rank_t hit_rank;
    logic  empty_found;
    slot_t empty_slot;
    rank_t old_rank;
    slot_t old_slot;
    page_t old_page;
  } srch_beat_t;

  // update beat: one slot becomes newest, others age below the limit
  typedef struct packed {
    logic   en;
    logic   miss;
    slot_t  slot;
    page_t  page;
    limit_t limit;
  } upd_beat_t;

  // effective frame count: zero acts as one, above the build size clamps
  function automatic cnt_t frames_in_use(input act_t v);
    cnt_t n;
    n = cnt_t'(MAX_FRAMES);
    if (v == '0) begin
      n = cnt_t'(1);
    end else if (int'(v) <= MAX_FRAMES) begin
      n = cnt_t'(v);
    end
    return n;
  endfunction

endpackage

@@ sv/lru_frame_replacer.sv @@
// ---------------------------------------------------------------------------
// lru_frame_replacer: least-recently-used page frame replacement
// Looks up a page among the active frames; a hit refreshes its frame, a
// miss fills the lowest empty frame or evicts the oldest one.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------
//  in_     | in  | in_valid/in_stall | in_page[7:0]
//  out_    | out | out_valid/out_stall| out_hit, out_frame_slot[2:0],
//          |     |                   | out_evicted_valid, out_evicted_page,
//          |     |                   | out_fault_count[15:0]
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_active_frames[3:0]
//
//  Sequence: the search beat walks the cell row one cell per clock, then the
//  decision is captured in res_r (S_DONE) and committed to all cells and the
//  output register once the output register is free.
//  Reset (rst_n low, synchronous): all frames empty, ranks zero, fault count
//  zero, active_frames = MAX_FRAMES.
//  Stalls: the output register holds a finished beat under out_stall while
//  the next input beat is already taken and searched; the commit waits only
//  for the output register to free up. cfg_ready is always high.
//
module lru_frame_replacer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_page,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [2:0]  out_frame_slot,
  output logic        out_evicted_valid,
  output logic [7:0]  out_evicted_page,
  output logic [15:0] out_fault_count,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_active_frames
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,   // waiting for an input beat
    S_SRCH = 3'b010,   // search beat in flight along the row
    S_DONE = 3'b100    // decision held, commit when output frees
  } state_t;

  state_t                state_r, state_nxt;
  lrufr_pkg::act_t       act_r, act_nxt;
  lrufr_pkg::cnt_t       n_use;
  logic [lrufr_pkg::MAX_FRAMES-1:0] cell_act;

  lrufr_pkg::srch_beat_t beat0_r, beat0_nxt;
  lrufr_pkg::srch_beat_t chain [lrufr_pkg::MAX_FRAMES+1];
  lrufr_pkg::srch_beat_t res_r, res_nxt;
  lrufr_pkg::upd_beat_t  upd;

  lrufr_pkg::fault_t     fault_r, fault_nxt;
  lrufr_pkg::slot_t      pick_slot;
  logic                  evict;
  logic                  in_acc, out_free, commit;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r;
  lrufr_pkg::slot_t      out_slot_r;
  logic                  out_ev_vld_r;
  lrufr_pkg::page_t      out_ev_page_r;
  lrufr_pkg::fault_t     out_fault_r;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_comb begin
    act_nxt = act_r;
    if (cfg_valid && cfg_ready) begin
      act_nxt = lrufr_pkg::act_t'(cfg_active_frames);
    end
  end

  assign n_use = lrufr_pkg::frames_in_use(act_r);

  // ---- input side ----
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    beat0_nxt             = '0;
    beat0_nxt.page        = lrufr_pkg::page_t'(in_page);
    beat0_nxt.vld         = in_acc;
  end

  // ---- cell row: the search beat advances one frame per clock ----
  assign chain[0] = beat0_r;

  for (genvar i = 0; i < lrufr_pkg::MAX_FRAMES; i++) begin : g_cell
    assign cell_act[i] = (n_use > lrufr_pkg::cnt_t'(i));

    lrufr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lrufr_pkg::slot_t'(i)),
      .cell_act (cell_act[i]),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1]),
      .upd      (upd)
    );
  end

  // ---- decision ----
  assign evict = !res_r.found && !res_r.empty_found;

  always_comb begin
    pick_slot = res_r.old_slot;
    if (res_r.found) begin
      pick_slot = res_r.hit_slot;
    end else if (res_r.empty_found) begin
      pick_slot = res_r.empty_slot;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_DONE) && out_free;

  // hit ages only frames younger than the hit; a miss ages every other valid frame, saturating at the top rank
  always_comb begin
    upd.en    = commit;
    upd.miss  = !res_r.found;
    upd.slot  = pick_slot;
    upd.page  = res_r.page;
    upd.limit = res_r.found ? {1'b0, res_r.hit_rank} : lrufr_pkg::LIMIT_FULL;
  end

  always_comb begin
    fault_nxt = fault_r;
    if (commit && !res_r.found && (fault_r != lrufr_pkg::FAULT_MAX)) begin
      fault_nxt = fault_r + 1'b1;
    end
  end

  // ---- sequencing ----
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (chain[lrufr_pkg::MAX_FRAMES].vld) begin
          res_nxt   = chain[lrufr_pkg::MAX_FRAMES];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= lrufr_pkg::ACT_RESET;
      fault_r     <= '0;
      beat0_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      fault_r     <= fault_nxt;
      beat0_r     <= beat0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (commit) begin
      out_hit_r     <= res_r.found;
      out_slot_r    <= pick_slot;
      out_ev_vld_r  <= evict;
      out_ev_page_r <= evict ? res_r.old_page : '0;
      out_fault_r   <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = 3'(out_slot_r);
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_page  = 8'(out_ev_page_r);
  assign out_fault_count   = 16'(out_fault_r);

endmodule

@@ sv/lrufr_cell.sv @@
// ---------------------------------------------------------------------------
// lrufr_cell: one frame of the replacer
// Holds page, valid and recency rank; refines the passing search beat
// and registers it toward the next cell; applies the commit broadcast.
// ---------------------------------------------------------------------------
module lrufr_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrufr_pkg::slot_t       cell_idx,
  input  logic                   cell_act,
  input  lrufr_pkg::srch_beat_t  beat_in,
  output lrufr_pkg::srch_beat_t  beat_out,
  input  lrufr_pkg::upd_beat_t   upd
);

  lrufr_pkg::page_t      page_r,  page_nxt;
  logic                  valid_r, valid_nxt;
  lrufr_pkg::rank_t      rank_r,  rank_nxt;
  lrufr_pkg::srch_beat_t beat_r,  beat_nxt;

  always_comb begin
    beat_nxt = beat_in;
    if (beat_in.vld && cell_act) begin
      if (!beat_in.found && valid_r && (page_r == beat_in.page)) begin
        beat_nxt.found    = 1'b1;
        beat_nxt.hit_slot = cell_idx;
        beat_nxt.hit_rank = rank_r;
      end
      if (!beat_in.empty_found && !valid_r) begin
        beat_nxt.empty_found = 1'b1;
        beat_nxt.empty_slot  = cell_idx;
      end
      // strictly older wins; frame zero seeds the pick
      if ((rank_r > beat_in.old_rank) || (cell_idx == '0)) begin
        beat_nxt.old_rank = rank_r;
        beat_nxt.old_slot = cell_idx;
        beat_nxt.old_page = page_r;
      end
    end
  end

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (upd.en && cell_act) begin
      if (upd.slot == cell_idx) begin
        rank_nxt = '0;
        if (upd.miss) begin
          page_nxt  = upd.page;
          valid_nxt = 1'b1;
        end
      end else if (valid_r && ({1'b0, rank_r} < upd.limit) &&
                   (rank_r < lrufr_pkg::RANK_MAX)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= '0;
      valid_r <= 1'b0;
      rank_r  <= '0;
      beat_r  <= '0;
    end else begin
      page_r  <= page_nxt;
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      beat_r  <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule

@@ sv/lrufr_chk.sv @@
// ---------------------------------------------------------------------------
// lrufr_chk: port-level checks for the LRU frame replacer
// Watches the channels of the top level; attached by bind.
// ---------------------------------------------------------------------------
module lrufr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [2:0]  out_frame_slot,
  input logic        out_evicted_valid,
  input logic [7:0]  out_evicted_page,
  input logic [15:0] out_fault_count
);

  // an accepted beat keeps the input closed while it is searched
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input reopened right after accepting a beat");

  // a hit never replaces a resident page
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("hit beat reports an eviction");

  // evicted page reads zero when nothing was replaced
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == 8'd0))
    else $error("evicted page nonzero without an eviction");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hit) &&
      $stable(out_frame_slot) && $stable(out_evicted_valid) &&
      $stable(out_evicted_page) && $stable(out_fault_count)))
    else $error("stalled result beat changed");

endmodule

bind lru_frame_replacer lrufr_chk u_lrufr_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_frame_slot    (out_frame_slot),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_count   (out_fault_count)
);
